@@ rtl/iee_pkg.sv @@
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types, token and status codes for the expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;
  localparam int StackDepth   = 32;
  localparam int ValueWidth   = 48;
  localparam int FractionBits = 16;
  localparam int PtrWidth     = $clog2(StackDepth);
  localparam int CountWidth   = $clog2(StackDepth + 1);

  typedef logic signed [ValueWidth-1:0] value_t;

  typedef enum logic [2:0] {
    TOK_NUM = 3'd0, TOK_ADD = 3'd1, TOK_SUB = 3'd2, TOK_MUL = 3'd3,
    TOK_DIV = 3'd4, TOK_OPEN = 3'd5, TOK_CLOSE = 3'd6, TOK_END = 3'd7
  } tok_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_PAREN = 3'd1, ST_OPERAND = 3'd2, ST_FULL = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  localparam value_t VMax = {1'b0, {(ValueWidth-1){1'b1}}};
  localparam value_t VMin = {1'b1, {(ValueWidth-1){1'b0}}};

  // request to the arithmetic unit
  typedef struct packed {
    logic   start;
    tok_t   op;
    value_t x;
    value_t y;
  } alu_req_t;

  // answer from the arithmetic unit
  typedef struct packed {
    logic   done;
    value_t r;
    logic   sat;
  } alu_rsp_t;

  // operator precedence
  function automatic logic [1:0] rank(input logic [2:0] op);
    if (op == TOK_MUL || op == TOK_DIV) return 2'd2;
    if (op == TOK_ADD || op == TOK_SUB) return 2'd1;
    return 2'd0;
  endfunction
endpackage

@@ rtl/iee_if.sv @@
// ----------------------------------------------------------------------------
// iee_tok_if / iee_res_if
// Valid/ready channels for tokens in and results out.
// ----------------------------------------------------------------------------
interface iee_tok_if import iee_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  value_t     number_value;
  modport source (output valid, mode, number_value, input ready);
  modport sink (input valid, mode, number_value, output ready);
endinterface

interface iee_res_if import iee_pkg::*; ();
  logic       valid;
  logic       ready;
  value_t     result_value;
  logic [2:0] status;
  logic       saturated;
  modport source (output valid, result_value, status, saturated, input ready);
  modport sink (input valid, result_value, status, saturated, output ready);
endinterface

@@ rtl/iee_alu.sv @@
// ----------------------------------------------------------------------------
// iee_alu
// Shared saturating fixed-point unit: add/sub in one step, multiply over
// four 24x24 partial products, divide one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iee_alu import iee_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);
  localparam int HalfW = ValueWidth / 2;
  localparam int ProdW = 2 * ValueWidth;
  localparam int NumW  = ValueWidth + FractionBits;
  localparam int StepW = $clog2(NumW + 1);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_MULFIN, S_DIV, S_DIVFIN, S_DONE} state_t;
  state_t state;

  logic                  neg;
  logic [ValueWidth-1:0] ma, mb;
  logic [ProdW-1:0]      acc;
  logic [1:0]            part;
  logic [NumW-1:0]       num;
  logic [ValueWidth:0]   rem;
  logic [NumW-1:0]       quo;
  logic [StepW-1:0]      step;
  value_t                r;
  logic                  sat;

  // magnitudes of the operands
  logic [ValueWidth-1:0] mag_x, mag_y;
  assign mag_x = req.x[ValueWidth-1] ? ValueWidth'(-req.x) : req.x;
  assign mag_y = req.y[ValueWidth-1] ? ValueWidth'(-req.y) : req.y;

  // add and subtract, combinational, with overflow detect
  logic [ValueWidth:0] sum;
  logic                ovf;
  always_comb begin
    if (req.op == TOK_ADD) begin
      sum = {req.x[ValueWidth-1], req.x} + {req.y[ValueWidth-1], req.y};
    end else begin
      sum = {req.x[ValueWidth-1], req.x} - {req.y[ValueWidth-1], req.y};
    end
    ovf = sum[ValueWidth] != sum[ValueWidth-1];
  end

  // one partial product per cycle
  logic [HalfW-1:0]       pa, pb;
  logic [2*HalfW-1:0]     pp;
  logic [ProdW-1:0]       pp_sh;
  always_comb begin
    pa = part[0] ? ma[ValueWidth-1:HalfW] : ma[HalfW-1:0];
    pb = part[1] ? mb[ValueWidth-1:HalfW] : mb[HalfW-1:0];
    pp = pa * pb;
    pp_sh = ProdW'(pp) << (HalfW * (32'(part[0]) + 32'(part[1])));
  end

  // restoring divide step
  logic [ValueWidth:0] rem_sh;
  logic                ge;
  always_comb begin
    rem_sh = {rem[ValueWidth-1:0], num[NumW-1]};
    ge = rem_sh >= {1'b0, mb};
  end

  // magnitude to signed with saturation
  logic [ProdW-1:0]  mq;
  logic [ProdW-1:0]  mag_w;
  logic [ProdW-1:0]  lim;
  always_comb begin
    mq = acc >> FractionBits;
    mag_w = (state == S_MULFIN) ? mq : ProdW'(quo);
    lim = neg ? ProdW'(VMax) + ProdW'(1) : ProdW'(VMax);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.start) begin
            neg <= req.x[ValueWidth-1] ^ req.y[ValueWidth-1];
            ma  <= mag_x;
            mb  <= mag_y;
            sat <= 1'b0;
            case (req.op)
              TOK_MUL: begin
                acc   <= '0;
                part  <= 2'd0;
                state <= S_MUL;
              end
              TOK_DIV: begin
                if (mag_y == '0) begin
                  r     <= req.x[ValueWidth-1] ? VMin : VMax;
                  sat   <= 1'b1;
                  state <= S_DONE;
                end else begin
                  num   <= NumW'(mag_x) << FractionBits;
                  rem   <= '0;
                  quo   <= '0;
                  step  <= StepW'(NumW);
                  state <= S_DIV;
                end
              end
              default: begin
                if (ovf) begin
                  r   <= req.x[ValueWidth-1] ? VMin : VMax;
                  sat <= 1'b1;
                end else begin
                  r <= sum[ValueWidth-1:0];
                end
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          acc  <= acc + pp_sh;
          part <= part + 2'd1;
          if (part == 2'd3) state <= S_MULFIN;
        end
        S_DIV: begin
          num  <= num << 1;
          quo  <= {quo[NumW-2:0], ge};
          rem  <= ge ? rem_sh - {1'b0, mb} : rem_sh;
          step <= step - StepW'(1);
          if (step == StepW'(1)) state <= S_DIVFIN;
        end
        S_MULFIN, S_DIVFIN: begin
          if (mag_w > lim) begin
            r   <= neg ? VMin : VMax;
            sat <= 1'b1;
          end else begin
            r <= neg ? ValueWidth'(-mag_w) : mag_w[ValueWidth-1:0];
          end
          state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = state == S_DONE;
  assign rsp.r    = r;
  assign rsp.sat  = sat;
endmodule

@@ rtl/infix_expression_evaluator_core.sv @@
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core
// Shunting-yard evaluator: operator and value stacks in memories, a
// sequencer that pops operators through one shared arithmetic unit.
// ----------------------------------------------------------------------------
// channel  dir  handshake     payload
// tok      in   valid/ready   mode, number_value
// res      out  valid/ready   result_value, status, saturated
//
// A number or open is taken straight from idle; an operator or close reads the
// operator top, then per operator applied fetches both operands, runs the shared
// unit (one quotient bit per cycle for divide; divide by zero skips the divide)
// and pushes the result. End pops the same way, then offers its result on res.
// Reset clears the counts and error latch; stack contents need no clearing.
// tok.ready is low while a token is being worked or a result waits on res.
module infix_expression_evaluator_core import iee_pkg::*; (
  input logic  clk,
  input logic  rst,
  iee_tok_if.sink   tok,
  iee_res_if.source res
);
  typedef enum logic [3:0] {
    S_IDLE, S_POPLOOK, S_OPRD, S_VRD1, S_VRD2, S_VRD3, S_ALU, S_PUSH,
    S_ENDRD, S_OUT
  } state_t;
  state_t state;

  logic [2:0]            op_mem [StackDepth];
  value_t                val_mem [StackDepth];
  logic [CountWidth-1:0] op_cnt, val_cnt;
  status_t               err;
  logic                  sat_seen;
  tok_t                  cur;
  logic [2:0]            top_op, pend_op;
  value_t                vrd, vx, vy;
  alu_req_t              req;
  alu_rsp_t              rsp;

  iee_alu u_alu (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign req.op = tok_t'(pend_op);
  assign req.x  = vx;
  assign req.y  = vy;
  assign req.start = state == S_VRD3;

  logic [PtrWidth-1:0] op_top_a, val_rd_a;
  assign op_top_a = PtrWidth'(op_cnt - CountWidth'(1));

  assign tok.ready = state == S_IDLE;
  assign res.valid = state == S_OUT;

  always_ff @(posedge clk) begin
    top_op <= op_mem[op_top_a];
    vrd    <= val_mem[val_rd_a];
  end

  always_comb begin
    val_rd_a = PtrWidth'(val_cnt - CountWidth'(1));
    if (state == S_VRD1) val_rd_a = PtrWidth'(val_cnt - CountWidth'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; op_cnt <= '0; val_cnt <= '0;
      err <= ST_OK; sat_seen <= 1'b0;
    end else begin
      case (state)
        // take a token
        S_IDLE: if (tok.valid) begin
          cur <= tok_t'(tok.mode);
          if (tok_t'(tok.mode) == TOK_END) state <= S_POPLOOK;
          else if (err != ST_OK) state <= S_IDLE;
          else case (tok_t'(tok.mode))
            TOK_NUM: if (val_cnt < CountWidth'(StackDepth)) begin
              val_mem[PtrWidth'(val_cnt)] <= tok.number_value;
              val_cnt <= val_cnt + CountWidth'(1);
            end else err <= ST_FULL;
            TOK_OPEN: if (op_cnt < CountWidth'(StackDepth)) begin
              op_mem[PtrWidth'(op_cnt)] <= TOK_OPEN;
              op_cnt <= op_cnt + CountWidth'(1);
            end else err <= ST_FULL;
            default: state <= S_POPLOOK;
          endcase
        end
        // wait for the top-of-stack read
        S_POPLOOK: state <= S_OPRD;
        // decide whether to pop
        S_OPRD: begin
          if (cur == TOK_END) begin
            if (err != ST_OK || op_cnt == '0) state <= S_ENDRD;
            else if (top_op == TOK_OPEN) begin
              err <= ST_PAREN; state <= S_ENDRD;
            end else begin
              pend_op <= top_op; op_cnt <= op_cnt - CountWidth'(1);
              state <= S_VRD1;
            end
          end else if (cur == TOK_CLOSE) begin
            if (op_cnt == '0) begin
              err <= ST_PAREN; state <= S_IDLE;
            end else if (top_op == TOK_OPEN) begin
              op_cnt <= op_cnt - CountWidth'(1); state <= S_IDLE;
            end else begin
              pend_op <= top_op; op_cnt <= op_cnt - CountWidth'(1);
              state <= S_VRD1;
            end
          end else begin
            if (op_cnt != '0 && rank(top_op) >= rank(cur)) begin
              pend_op <= top_op; op_cnt <= op_cnt - CountWidth'(1);
              state <= S_VRD1;
            end else begin
              if (op_cnt < CountWidth'(StackDepth)) begin
                op_mem[PtrWidth'(op_cnt)] <= cur;
                op_cnt <= op_cnt + CountWidth'(1);
              end else err <= ST_FULL;
              state <= S_IDLE;
            end
          end
        end
        // fetch both operands
        S_VRD1: begin
          vy <= vrd;
          if (val_cnt < CountWidth'(2)) begin
            err <= ST_OPERAND;
            state <= (cur == TOK_END) ? S_ENDRD : S_IDLE;
          end else state <= S_VRD2;
        end
        S_VRD2: begin vx <= vrd; state <= S_VRD3; end
        S_VRD3: state <= S_ALU;
        S_ALU: if (rsp.done) begin
          val_mem[PtrWidth'(val_cnt - CountWidth'(2))] <= rsp.r;
          val_cnt <= val_cnt - CountWidth'(1);
          sat_seen <= sat_seen | rsp.sat;
          state <= S_PUSH;
        end
        // let the new counts settle, then look again
        S_PUSH: state <= S_POPLOOK;
        S_ENDRD: begin
          if (err == ST_OK && val_cnt == '0) err <= ST_EMPTY;
          state <= S_OUT;
        end
        S_OUT: if (res.ready) begin
          op_cnt <= '0; val_cnt <= '0; err <= ST_OK; sat_seen <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.result_value = (err == ST_OK) ? vrd : '0;
  assign res.status       = err;
  assign res.saturated    = sat_seen;

  // counts stay within the stacks
  a_opcnt: assert property (@(posedge clk) disable iff (rst)
    op_cnt <= CountWidth'(StackDepth)) else $error("operator count overflow");
  a_valcnt: assert property (@(posedge clk) disable iff (rst)
    val_cnt <= CountWidth'(StackDepth)) else $error("value count overflow");
  // a result is followed by cleared state
  a_clear: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready |=> val_cnt == '0 && err == ST_OK)
    else $error("state not cleared after result");
endmodule
